// ===== rtl/dcalc_pkg.sv =====
package dcalc_pkg;

    localparam int MANT_W      = 48;
    localparam int VAL_W       = 47;
    localparam int CNT_W       = 3;
    localparam int FRAC_BITS   = 16;
    localparam logic [CNT_W-1:0] FRAC_DIGITS = 3'd4;

    // shared unit: low word holds the dividend or the multiplier
    localparam int LO_W        = MANT_W + FRAC_BITS;
    localparam int STEP_CW     = $clog2(LO_W);
    localparam int MAG_W       = MANT_W + LO_W - FRAC_BITS;

    localparam logic [63:0] INT_LIMIT = 64'd1 << (47 - FRAC_BITS);
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
    localparam logic [MANT_W-1:0] MANT_MAX = {MANT_W{1'b1}};

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_DIVZERO = 3'd2,
        ST_NOOP    = 3'd3,
        ST_OVF     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MDU_MUL = 2'b01,
        MDU_DIV = 2'b10
    } mdu_mode_t;

    typedef struct packed {
        logic [MANT_W-1:0] first_mant;
        logic [CNT_W-1:0]  first_cnt;
        logic [MANT_W-1:0] second_mant;
        logic [CNT_W-1:0]  second_cnt;
        logic              neg;
        logic              op_seen;
        op_t               op;
        logic              err;
    } parse_state_t;

    function automatic logic [MANT_W-1:0] pow10(input logic [CNT_W-1:0] cnt);
        logic [MANT_W-1:0] p;
        unique case (cnt)
            3'd0: p = 48'd1;
            3'd1: p = 48'd10;
            3'd2: p = 48'd100;
            3'd3: p = 48'd1000;
            3'd4: p = 48'd10000;
            3'd5: p = 48'd100000;
            3'd6: p = 48'd1000000;
            3'd7: p = 48'd10000000;
            default: p = 48'd1;
        endcase
        return p;
    endfunction

    // integer-part limit scaled by 10^cnt
    function automatic logic [63:0] int_lim(input logic [CNT_W-1:0] cnt);
        logic [63:0] l;
        unique case (cnt)
            3'd0: l = INT_LIMIT;
            3'd1: l = INT_LIMIT * 64'd10;
            3'd2: l = INT_LIMIT * 64'd100;
            3'd3: l = INT_LIMIT * 64'd1000;
            3'd4: l = INT_LIMIT * 64'd10000;
            3'd5: l = INT_LIMIT * 64'd100000;
            3'd6: l = INT_LIMIT * 64'd1000000;
            3'd7: l = INT_LIMIT * 64'd10000000;
            default: l = INT_LIMIT;
        endcase
        return l;
    endfunction

endpackage

// ===== rtl/dcalc_in_if.sv =====
interface dcalc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       text_end;

    modport source (output valid, output text_byte, output text_end, input ready);
    modport sink (input valid, input text_byte, input text_end, output ready);
endinterface

// ===== rtl/dcalc_out_if.sv =====
interface dcalc_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] first_operand;
    logic [46:0] second_operand;
    logic [47:0] result_value;
    logic [1:0]  operator_code;
    logic [2:0]  status;

    modport source (output valid, output first_operand, output second_operand,
                    output result_value, output operator_code, output status,
                    input ready);
    modport sink (input valid, input first_operand, input second_operand,
                  input result_value, input operator_code, input status,
                  output ready);
endinterface

// ===== rtl/decimal_expression_calculator_unit.sv =====
// characters: one transaction per cycle while the unit is idle, each registered in the parser
// terminator: 2 passes of the shared shift/add-subtract unit (64 steps each) to
// scale both operands, a third pass for multiply or divide; the result is then held
// valid until it is taken, and no characters are taken meanwhile
// asynchronous active-low reset returns the parser to an empty expression
module decimal_expression_calculator_unit (
    input  logic        clk,
    input  logic        rst_n,
    dcalc_in_if.sink    expr,
    dcalc_out_if.source result
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CONV_A = 6'b000010,
        S_CONV_B = 6'b000100,
        S_OPER   = 6'b001000,
        S_RUN_OP = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    localparam int SUM_W = dcalc_pkg::MANT_W + 2;
    localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(dcalc_pkg::VAL_MAX);
    localparam logic signed [SUM_W-1:0] NEG_MIN = -SUM_W'(dcalc_pkg::VAL_MAX) - 1;
    localparam logic [dcalc_pkg::MAG_W-1:0] MAG_POS = dcalc_pkg::MAG_W'(dcalc_pkg::VAL_MAX);
    localparam logic [dcalc_pkg::MAG_W-1:0] MAG_NEG = MAG_POS + 1'b1;
    localparam logic [47:0] SAT_POS = {1'b0, dcalc_pkg::VAL_MAX};
    localparam logic [47:0] SAT_NEG = {1'b1, {dcalc_pkg::VAL_W{1'b0}}};

    state_t                         state_reg, state_next;
    dcalc_pkg::parse_state_t        pstate;
    logic                           char_valid, term_valid, out_take;

    logic                           mdu_start, mdu_done;
    dcalc_pkg::mdu_mode_t           mdu_mode;
    logic [dcalc_pkg::MANT_W-1:0]   mdu_opnd, mdu_hi;
    logic [dcalc_pkg::LO_W-1:0]     mdu_init, mdu_lo;

    logic [dcalc_pkg::VAL_W-1:0]    qa_reg, qa_next, qb_reg, qb_next;
    logic                           ovf_reg, ovf_next;
    logic                           valid_reg, valid_next;
    logic [47:0]                    first_reg, first_next, res_reg, res_next;
    dcalc_pkg::status_t             st_reg, st_next;

    logic                           ovf_a, ovf_b;
    logic [dcalc_pkg::VAL_W-1:0]    conv_q;
    logic [dcalc_pkg::MANT_W:0]     a_val;
    logic signed [SUM_W-1:0]        as_sum;
    logic [dcalc_pkg::MAG_W-1:0]    mag;
    logic                           mag_ovf;

    assign char_valid = expr.valid && expr.ready && !expr.text_end;
    assign term_valid = expr.valid && expr.ready && expr.text_end;
    assign out_take   = result.valid && result.ready;

    dcalc_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_byte  (expr.text_byte),
        .clear      (out_take),
        .pstate     (pstate)
    );

    dcalc_mdu u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mdu_start),
        .mode  (mdu_mode),
        .opnd  (mdu_opnd),
        .init  (mdu_init),
        .done  (mdu_done),
        .hi    (mdu_hi),
        .lo    (mdu_lo)
    );

    always_comb
    begin
        ovf_a  = {16'b0, pstate.first_mant} >= dcalc_pkg::int_lim(pstate.first_cnt);
        ovf_b  = {16'b0, pstate.second_mant} >= dcalc_pkg::int_lim(pstate.second_cnt);
        conv_q = mdu_lo[dcalc_pkg::VAL_W-1:0];
        a_val  = pstate.neg ? -{2'b0, qa_reg} : {2'b0, qa_reg};

        if (pstate.op == dcalc_pkg::OP_SUB)
            as_sum = signed'({a_val[dcalc_pkg::MANT_W], a_val}) - signed'(SUM_W'(qb_reg));
        else
            as_sum = signed'({a_val[dcalc_pkg::MANT_W], a_val}) + signed'(SUM_W'(qb_reg));

        // product drops its fraction bits, quotient comes out already scaled
        if (pstate.op == dcalc_pkg::OP_MUL)
            mag = {mdu_hi, mdu_lo[dcalc_pkg::LO_W-1:dcalc_pkg::FRAC_BITS]};
        else
            mag = dcalc_pkg::MAG_W'(mdu_lo);
        mag_ovf = pstate.neg ? (mag > MAG_NEG) : (mag > MAG_POS);

        mdu_start = 1'b0;
        mdu_mode  = dcalc_pkg::MDU_DIV;
        mdu_opnd  = dcalc_pkg::pow10(pstate.first_cnt);
        mdu_init  = {pstate.first_mant, {dcalc_pkg::FRAC_BITS{1'b0}}};

        state_next = state_reg;
        qa_next    = qa_reg;
        qb_next    = qb_reg;
        ovf_next   = ovf_reg;
        valid_next = valid_reg;
        first_next = first_reg;
        res_next   = res_reg;
        st_next    = st_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (term_valid)
                begin
                    mdu_start  = 1'b1;
                    ovf_next   = 1'b0;
                    state_next = S_CONV_A;
                end
            end
            S_CONV_A:
            begin
                mdu_opnd = dcalc_pkg::pow10(pstate.second_cnt);
                mdu_init = {pstate.second_mant, {dcalc_pkg::FRAC_BITS{1'b0}}};
                if (mdu_done)
                begin
                    qa_next    = ovf_a ? dcalc_pkg::VAL_MAX : conv_q;
                    ovf_next   = ovf_a;
                    mdu_start  = 1'b1;
                    state_next = S_CONV_B;
                end
            end
            S_CONV_B:
            begin
                if (mdu_done)
                begin
                    qb_next    = ovf_b ? dcalc_pkg::VAL_MAX : conv_q;
                    ovf_next   = ovf_reg | ovf_b;
                    state_next = S_OPER;
                end
            end
            S_OPER:
            begin
                first_next = a_val[47:0];
                res_next   = '0;
                if (pstate.op == dcalc_pkg::OP_MUL)
                begin
                    mdu_mode = dcalc_pkg::MDU_MUL;
                    mdu_opnd = {1'b0, qa_reg};
                    mdu_init = dcalc_pkg::LO_W'(qb_reg);
                end
                else
                begin
                    mdu_opnd = {1'b0, qb_reg};
                    mdu_init = dcalc_pkg::LO_W'({qa_reg, {dcalc_pkg::FRAC_BITS{1'b0}}});
                end
                priority if (pstate.err)
                begin
                    st_next    = dcalc_pkg::ST_INVALID;
                    valid_next = 1'b1;
                    state_next = S_OUT;
                end
                else if (!pstate.op_seen)
                begin
                    st_next    = dcalc_pkg::ST_NOOP;
                    valid_next = 1'b1;
                    state_next = S_OUT;
                end
                else if (pstate.op == dcalc_pkg::OP_DIV && qb_reg == '0)
                begin
                    st_next    = dcalc_pkg::ST_DIVZERO;
                    valid_next = 1'b1;
                    state_next = S_OUT;
                end
                else if (pstate.op == dcalc_pkg::OP_MUL || pstate.op == dcalc_pkg::OP_DIV)
                begin
                    mdu_start  = 1'b1;
                    state_next = S_RUN_OP;
                end
                else
                begin
                    priority if (as_sum > POS_MAX)
                    begin
                        res_next = SAT_POS;
                        st_next  = dcalc_pkg::ST_OVF;
                    end
                    else if (as_sum < NEG_MIN)
                    begin
                        res_next = SAT_NEG;
                        st_next  = dcalc_pkg::ST_OVF;
                    end
                    else
                    begin
                        res_next = as_sum[47:0];
                        st_next  = ovf_reg ? dcalc_pkg::ST_OVF : dcalc_pkg::ST_OK;
                    end
                    valid_next = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_RUN_OP:
            begin
                if (mdu_done)
                begin
                    if (mag_ovf)
                        res_next = pstate.neg ? SAT_NEG : SAT_POS;
                    else if (pstate.neg)
                        res_next = -mag[47:0];
                    else
                        res_next = mag[47:0];
                    st_next    = (mag_ovf || ovf_reg) ? dcalc_pkg::ST_OVF : dcalc_pkg::ST_OK;
                    valid_next = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_take)
                begin
                    valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qa_reg    <= qa_next;
        qb_reg    <= qb_next;
        first_reg <= first_next;
        res_reg   <= res_next;
        st_reg    <= st_next;
    end

    assign expr.ready            = (state_reg == S_IDLE);
    assign result.valid          = valid_reg;
    assign result.first_operand  = first_reg;
    assign result.second_operand = qb_reg;
    assign result.result_value   = res_reg;
    assign result.operator_code  = pstate.op;
    assign result.status         = st_reg;

endmodule

// ===== rtl/dcalc_mdu.sv =====
module dcalc_mdu (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  dcalc_pkg::mdu_mode_t           mode,
    input  logic [dcalc_pkg::MANT_W-1:0]   opnd,
    input  logic [dcalc_pkg::LO_W-1:0]     init,
    output logic                           done,
    output logic [dcalc_pkg::MANT_W-1:0]   hi,
    output logic [dcalc_pkg::LO_W-1:0]     lo
);

    logic                              run_reg, run_next;
    logic                              done_reg, done_next;
    logic [dcalc_pkg::STEP_CW-1:0]     cnt_reg, cnt_next;
    dcalc_pkg::mdu_mode_t              mode_reg, mode_next;
    logic [dcalc_pkg::MANT_W-1:0]      opnd_reg, opnd_next;
    logic [dcalc_pkg::MANT_W-1:0]      hi_reg, hi_next;
    logic [dcalc_pkg::LO_W-1:0]        lo_reg, lo_next;
    logic [dcalc_pkg::MANT_W:0]        trial, diff, sum;
    logic                              ge;

    always_comb
    begin
        // restoring divide step
        trial = {hi_reg, lo_reg[dcalc_pkg::LO_W-1]};
        diff  = trial - {1'b0, opnd_reg};
        ge    = (trial >= {1'b0, opnd_reg});
        // shift-add multiply step
        sum   = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, opnd_reg} : '0);

        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mode_next = mode_reg;
        opnd_next = opnd_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = '0;
            mode_next = mode;
            opnd_next = opnd;
            hi_next   = '0;
            lo_next   = init;
        end
        else if (run_reg)
        begin
            unique case (mode_reg)
                dcalc_pkg::MDU_DIV:
                begin
                    hi_next = ge ? diff[dcalc_pkg::MANT_W-1:0] : trial[dcalc_pkg::MANT_W-1:0];
                    lo_next = {lo_reg[dcalc_pkg::LO_W-2:0], ge};
                end
                dcalc_pkg::MDU_MUL:
                begin
                    hi_next = sum[dcalc_pkg::MANT_W:1];
                    lo_next = {sum[0], lo_reg[dcalc_pkg::LO_W-1:1]};
                end
                default:
                begin
                    hi_next = hi_reg;
                    lo_next = lo_reg;
                end
            endcase
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == dcalc_pkg::STEP_CW'(dcalc_pkg::LO_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= dcalc_pkg::MDU_MUL;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
    end

    assign done = done_reg;
    assign hi   = hi_reg;
    assign lo   = lo_reg;

endmodule

// ===== rtl/dcalc_parse.sv =====
module dcalc_parse (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_valid,
    input  logic [7:0]              char_byte,
    input  logic                    clear,
    output dcalc_pkg::parse_state_t pstate
);

    typedef struct packed {
        logic [dcalc_pkg::MANT_W-1:0] mant;
        logic [dcalc_pkg::CNT_W-1:0]  cnt;
    } acc_t;

    logic [dcalc_pkg::MANT_W-1:0] first_mant_reg, first_mant_next;
    logic [dcalc_pkg::CNT_W-1:0]  first_cnt_reg, first_cnt_next;
    logic [dcalc_pkg::MANT_W-1:0] second_mant_reg, second_mant_next;
    logic [dcalc_pkg::CNT_W-1:0]  second_cnt_reg, second_cnt_next;
    logic                         neg_reg, neg_next;
    logic                         in_frac_reg, in_frac_next;
    logic                         op_seen_reg, op_seen_next;
    dcalc_pkg::op_t               op_reg, op_next;
    logic                         at_start_reg, at_start_next;
    logic                         err_reg, err_next;

    logic                         is_op;
    dcalc_pkg::op_t               op_code;
    logic                         is_digit;
    logic [3:0]                   digit;
    acc_t                         acc_in, acc_out;

    function automatic acc_t add_digit(input acc_t a, input logic [3:0] d, input logic frac);
        acc_t  r;
        logic [dcalc_pkg::MANT_W+3:0] t;
        r = a;
        t = ({4'b0, a.mant} << 3) + ({4'b0, a.mant} << 1) + {{dcalc_pkg::MANT_W{1'b0}}, d};
        if (!frac)
        begin
            if ({16'b0, a.mant} < dcalc_pkg::INT_LIMIT)
                r.mant = t[dcalc_pkg::MANT_W-1:0];
        end
        else if (a.cnt < dcalc_pkg::FRAC_DIGITS
                 && {16'b0, a.mant} < dcalc_pkg::int_lim(a.cnt)
                 && t <= {4'b0, dcalc_pkg::MANT_MAX})
        begin
            r.mant = t[dcalc_pkg::MANT_W-1:0];
            r.cnt  = a.cnt + 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        is_op   = 1'b1;
        op_code = dcalc_pkg::OP_ADD;
        priority if (char_byte == dcalc_pkg::CH_PLUS)  op_code = dcalc_pkg::OP_ADD;
        else if (char_byte == dcalc_pkg::CH_MINUS)     op_code = dcalc_pkg::OP_SUB;
        else if (char_byte == dcalc_pkg::CH_STAR)      op_code = dcalc_pkg::OP_MUL;
        else if (char_byte == dcalc_pkg::CH_SLASH)     op_code = dcalc_pkg::OP_DIV;
        else                                           is_op = 1'b0;

        is_digit = (char_byte >= dcalc_pkg::CH_ZERO) && (char_byte <= dcalc_pkg::CH_NINE);
        digit    = char_byte[3:0];

        acc_in.mant = op_seen_reg ? second_mant_reg : first_mant_reg;
        acc_in.cnt  = op_seen_reg ? second_cnt_reg : first_cnt_reg;
        acc_out     = add_digit(acc_in, digit, in_frac_reg);

        first_mant_next  = first_mant_reg;
        first_cnt_next   = first_cnt_reg;
        second_mant_next = second_mant_reg;
        second_cnt_next  = second_cnt_reg;
        neg_next         = neg_reg;
        in_frac_next     = in_frac_reg;
        op_seen_next     = op_seen_reg;
        op_next          = op_reg;
        at_start_next    = at_start_reg;
        err_next         = err_reg;

        if (clear)
        begin
            first_mant_next  = '0;
            first_cnt_next   = '0;
            second_mant_next = '0;
            second_cnt_next  = '0;
            neg_next         = 1'b0;
            in_frac_next     = 1'b0;
            op_seen_next     = 1'b0;
            op_next          = dcalc_pkg::OP_ADD;
            at_start_next    = 1'b1;
            err_next         = 1'b0;
        end
        else if (char_valid)
        begin
            at_start_next = 1'b0;
            if (!err_reg)
            begin
                // leading minus is a sign, a later one is subtract, or an error after another operator
                priority if (at_start_reg && char_byte == dcalc_pkg::CH_MINUS)
                    neg_next = 1'b1;
                else if (is_op)
                begin
                    if (op_seen_reg)
                        err_next = 1'b1;
                    else
                    begin
                        op_seen_next = 1'b1;
                        op_next      = op_code;
                        in_frac_next = 1'b0;
                    end
                end
                else if (char_byte == dcalc_pkg::CH_DOT)
                    in_frac_next = 1'b1;
                else if (is_digit)
                begin
                    if (op_seen_reg)
                    begin
                        second_mant_next = acc_out.mant;
                        second_cnt_next  = acc_out.cnt;
                    end
                    else
                    begin
                        first_mant_next = acc_out.mant;
                        first_cnt_next  = acc_out.cnt;
                    end
                end
                else
                    err_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_mant_reg  <= '0;
            first_cnt_reg   <= '0;
            second_mant_reg <= '0;
            second_cnt_reg  <= '0;
            neg_reg         <= 1'b0;
            in_frac_reg     <= 1'b0;
            op_seen_reg     <= 1'b0;
            op_reg          <= dcalc_pkg::OP_ADD;
            at_start_reg    <= 1'b1;
            err_reg         <= 1'b0;
        end
        else
        begin
            first_mant_reg  <= first_mant_next;
            first_cnt_reg   <= first_cnt_next;
            second_mant_reg <= second_mant_next;
            second_cnt_reg  <= second_cnt_next;
            neg_reg         <= neg_next;
            in_frac_reg     <= in_frac_next;
            op_seen_reg     <= op_seen_next;
            op_reg          <= op_next;
            at_start_reg    <= at_start_next;
            err_reg         <= err_next;
        end
    end

    assign pstate.first_mant  = first_mant_reg;
    assign pstate.first_cnt   = first_cnt_reg;
    assign pstate.second_mant = second_mant_reg;
    assign pstate.second_cnt  = second_cnt_reg;
    assign pstate.neg         = neg_reg;
    assign pstate.op_seen     = op_seen_reg;
    assign pstate.op          = op_reg;
    assign pstate.err         = err_reg;

endmodule
